[hw/rtl/bwc_pkg.sv]
// ----------------------------------------------------------------------------
// bwc_pkg - shared definitions for the block word checksum
// Widths, register indexes and the structs passed between the top level and
// the accumulator.
// ----------------------------------------------------------------------------
package bwc_pkg;

    localparam int unsigned MaxWords = 256;
    localparam int unsigned WordW    = 32;
    localparam int unsigned SkipW    = 8;
    localparam int unsigned IdxW     = $clog2(MaxWords + 1);
    localparam int unsigned CmpW     = (IdxW > SkipW) ? IdxW : SkipW;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = SkipW;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] RegBootMode  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegSkipIndex = CfgIdxW'(1);

    localparam logic [SkipW-1:0] SkipIndexReset = SkipW'(5);
    // Word left out of the sum in boot mode
    localparam logic [IdxW-1:0]  BootSkipIdx    = IdxW'(1);

    typedef struct packed {
        logic             boot_mode;
        logic [SkipW-1:0] skip_index;
    } t_cfg;

    typedef struct packed {
        logic [WordW-1:0] checksum;
        logic             overlength;
    } t_result;

endpackage

[hw/rtl/bwc_if.sv]
// ----------------------------------------------------------------------------
// bwc_in_if / bwc_out_if - request channels of the block word checksum
// Valid/ready channels carrying block words in and checksums out.
// ----------------------------------------------------------------------------
interface bwc_in_if;
    logic                      valid;
    logic                      ready;
    logic [bwc_pkg::WordW-1:0] data_word;
    logic                      last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface bwc_out_if;
    logic                      valid;
    logic                      ready;
    logic [bwc_pkg::WordW-1:0] checksum;
    logic                      overlength;

    modport source (output valid, output checksum, output overlength, input ready);
    modport sink   (input valid, input checksum, input overlength, output ready);
endinterface

[hw/rtl/bwc_accum.sv]
// ----------------------------------------------------------------------------
// bwc_accum - running sum and word index of the block checksum
// Holds the per-block state, adds each advanced word unless it is skipped or
// the index has saturated, and forms the result that the final word produces.
// ----------------------------------------------------------------------------
module bwc_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bwc_pkg::t_cfg               i_cfg,
    input  logic                        i_advance,
    input  logic [bwc_pkg::WordW-1:0]   i_word,
    input  logic                        i_last,
    output bwc_pkg::t_result            o_result
);

    logic [bwc_pkg::WordW-1:0] r_sum;
    logic [bwc_pkg::IdxW-1:0]  r_idx;
    logic                      r_too_long;

    logic [bwc_pkg::WordW-1:0] n_sum;
    logic [bwc_pkg::IdxW-1:0]  n_idx;
    logic                      n_too_long;

    logic                      sat;
    logic                      skip;
    logic [bwc_pkg::WordW:0]   add_full;
    logic [bwc_pkg::WordW-1:0] add_sum;
    logic [bwc_pkg::WordW-1:0] upd_sum;

    always_comb begin
        sat = (r_idx >= bwc_pkg::IdxW'(bwc_pkg::MaxWords));
        if (i_cfg.boot_mode) begin
            skip = (r_idx == bwc_pkg::BootSkipIdx);
        end else begin
            skip = (bwc_pkg::CmpW'(r_idx) == bwc_pkg::CmpW'(i_cfg.skip_index));
        end

        add_full = {1'b0, r_sum} + {1'b0, i_word};
        // Fold the carry back into bit 0 in boot mode; this cannot carry again
        if (i_cfg.boot_mode) begin
            add_sum = add_full[bwc_pkg::WordW-1:0]
                    + bwc_pkg::WordW'(add_full[bwc_pkg::WordW]);
        end else begin
            add_sum = add_full[bwc_pkg::WordW-1:0];
        end

        upd_sum = (sat || skip) ? r_sum : add_sum;

        o_result.checksum   = i_cfg.boot_mode ? ~upd_sum : (~upd_sum + 1'b1);
        o_result.overlength = r_too_long | sat;

        n_sum      = r_sum;
        n_idx      = r_idx;
        n_too_long = r_too_long;
        if (i_advance) begin
            if (i_last) begin
                n_sum      = '0;
                n_idx      = '0;
                n_too_long = 1'b0;
            end else begin
                n_sum      = upd_sum;
                n_idx      = sat ? r_idx : (r_idx + 1'b1);
                n_too_long = r_too_long | sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_idx      <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_idx      <= n_idx;
            r_too_long <= n_too_long;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= bwc_pkg::IdxW'(bwc_pkg::MaxWords))
        else $error("word index beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_last) |=> (r_idx == '0 && r_sum == '0 && !r_too_long))
        else $error("block state not cleared after final word");

    a_too_long_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_idx == bwc_pkg::IdxW'(bwc_pkg::MaxWords)))
        else $error("overlength set without saturated index");

endmodule

[hw/rtl/block_word_checksum.sv]
// ----------------------------------------------------------------------------
// block_word_checksum - streaming checksum of a disk block
// Sums a block of 32-bit words and returns the value for its checksum word,
// in data-block (negated wrapping sum) or boot (complemented end-around) form.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                    Moves
//  i_in      in   data_word[31:0] last_word  one block word per request
//  o_res     out  checksum[31:0] overlength  one result per block
//  i_cfg_*   in   index, data[7:0]           register write, no handshake
//
//  One word per cycle sustained but for the stall named below. A word is held
//  in the input register, then added into the running sum; the final word's
//  checksum is loaded from there into the output register, with the 32-bit
//  add and the boot carry fold or data negation between the two registers.
//  The input side keeps running while a result waits, stalling only when a
//  final word finds the output register still full. Reset clears the block
//  state and loads boot_mode 0, skip_index 5.
//
module block_word_checksum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bwc_in_if.sink                        i_in,
    bwc_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [bwc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [bwc_pkg::CfgDataW-1:0]  i_cfg_data
);

    // Configuration registers
    logic                      r_boot_mode;
    logic [bwc_pkg::SkipW-1:0] r_skip_index;
    bwc_pkg::t_cfg             cfg;

    // Input register
    logic                      r_s1_valid;
    logic [bwc_pkg::WordW-1:0] r_s1_word;
    logic                      r_s1_last;

    // Output register
    logic                      r_out_valid;
    bwc_pkg::t_result          r_out;

    bwc_pkg::t_result          result;
    logic                      out_free;
    logic                      s1_advance;
    logic                      in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_mode  <= 1'b0;
            r_skip_index <= bwc_pkg::SkipIndexReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bwc_pkg::RegBootMode:  r_boot_mode  <= i_cfg_data[0];
                bwc_pkg::RegSkipIndex: r_skip_index <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.boot_mode  = r_boot_mode;
    assign cfg.skip_index = r_skip_index;

    // A final word needs the output register; any other word always drains
    assign out_free   = !r_out_valid || o_res.ready;
    assign s1_advance = r_s1_valid && (!r_s1_last || out_free);
    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // Hold the payload unless a new request is taken
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word <= i_in.data_word;
            r_s1_last <= i_in.last_word;
        end
    end

    bwc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (s1_advance),
        .i_word    (r_s1_word),
        .i_last    (r_s1_last),
        .o_result  (result)
    );

    // Load a result on a final word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out <= result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.checksum   = r_out.checksum;
    assign o_res.overlength = r_out.overlength;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    a_final_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_last) |=> r_out_valid)
        else $error("final word produced no result");

    a_stall_only_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |-> (r_s1_last && r_out_valid && !o_res.ready))
        else $error("input stage stalled without cause");

endmodule
